// File: hdl/lwas_pkg.sv
// shared constants and codes for the link watchdog and arming supervisor
`timescale 1ns / 1ps

package lwas_pkg;

    // item kinds on the request channel
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_BEAT   = 2'd1,
        FUNC_ARM    = 2'd2,
        FUNC_DISARM = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ATT_LIMIT   = 3'd0,
        CFG_TEMP_LIMIT  = 3'd1,
        CFG_BATT_LOW    = 3'd2,
        CFG_LINK_TMO    = 3'd3,
        CFG_SEND_PERIOD = 3'd4
    } cfg_index_t;

    // datapath sizes
    localparam int ACC_W   = 32;
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = ACC_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(DIGITS);
    localparam int QUO_W   = 24;
    localparam int QUO_CNT_W = $clog2(QUO_W);
    localparam int CFG_DATA_W = 24;

    // accumulator slots
    localparam int ACC_HB  = 0;
    localparam int ACC_WIN = 1;
    localparam int ACC_SND = 2;
    localparam int ACC_NUM = 3;

    // limit flag bits
    localparam int FLAG_ATT  = 0;
    localparam int FLAG_TEMP = 1;
    localparam int FLAG_BATT = 2;

    // rate measurement window
    localparam logic [ACC_W-1:0] RATE_WINDOW_US = 32'd1000000;

    // register reset values
    localparam logic [14:0] ATT_LIMIT_RST   = 15'd6000;
    localparam logic [14:0] TEMP_LIMIT_RST  = 15'd8000;
    localparam logic [6:0]  BATT_LOW_RST    = 7'd10;
    localparam logic [23:0] LINK_TMO_RST    = 24'd2000000;
    localparam logic [19:0] SEND_PERIOD_RST = 20'd50000;

endpackage

// File: hdl/link_watchdog_arming_supervisor.sv
// link watchdog and arming supervisor top level
`timescale 1ns / 1ps

// Supervises the command link and arming of a flight controller.
// Request channel: in_valid/in_stall with func and the tick fields; func selects
// tick, heartbeat received, arm or disarm. Every request gives one result on the
// out_valid/out_stall channel carrying the flags, the send pulse, the last
// heartbeat rate (Q8.8 beats per microsecond) and the rate-update pulse.
// Configuration: cfg_we/cfg_index/cfg_data write one limit register per cycle.
// Sequence: heartbeat, arm and disarm go from accept straight to the done state. A tick
// runs its three 32-bit accumulators through a 4-bit digit-serial adder and
// comparator, lsb digit first, then a decision state. A tick that closes the
// rate window adds a restoring divider at one quotient bit per cycle for the
// 24-bit quotient. One request is in work at a time; the next is taken once the
// result has moved to the output register.
// Reset clears all accumulators, counters and flags and loads the default limits.
// A stalled result holds in the output register; while it holds, the block stalls
// the request side once the next result is ready.

module link_watchdog_arming_supervisor (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] elapsed_us,
    input  logic signed [15:0] roll_cdeg,
    input  logic signed [15:0] pitch_cdeg,
    input  logic signed [14:0] imu_temp_cdeg,
    input  logic [6:0]  battery_percent,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        armed_flag,
    output logic        link_online,
    output logic        attitude_exceeded,
    output logic        temperature_exceeded,
    output logic        battery_low,
    output logic        send_heartbeat,
    output logic [15:0] heart_rate_q8,
    output logic        rate_updated,
    // configuration port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [lwas_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_DECIDE,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam int AW = lwas_pkg::ACC_W;
    localparam int DW = lwas_pkg::DIGIT_W;
    localparam int NA = lwas_pkg::ACC_NUM;
    localparam int QW = lwas_pkg::QUO_W;

    state_t state_reg, state_next;
    logic [lwas_pkg::DIGIT_CNT_W-1:0] dig_reg, dig_next;
    logic [lwas_pkg::QUO_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0] dt_reg, dt_next;
    logic [AW-1:0] acc_reg [NA];
    logic [AW-1:0] acc_next [NA];
    logic [NA-1:0] carry_reg, carry_next;
    logic [NA-1:0] ge_reg, ge_next;
    logic [15:0]   beat_reg, beat_next;
    logic [15:0]   rate_reg, rate_next;
    logic          online_reg, online_next;
    logic          armed_reg, armed_next;
    logic [2:0]    flags_reg, flags_next;
    logic          send_reg, send_next;
    logic          upd_reg, upd_next;
    logic [AW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;

    logic [14:0]   att_lim_reg, att_lim_next;
    logic [14:0]   temp_lim_reg, temp_lim_next;
    logic [6:0]    batt_low_reg, batt_low_next;
    logic [23:0]   tmo_reg, tmo_next;
    logic [19:0]   period_reg, period_next;

    logic          out_valid_reg, out_valid_next;
    logic          o_armed_reg, o_armed_next;
    logic          o_online_reg, o_online_next;
    logic [2:0]    o_flags_reg, o_flags_next;
    logic          o_send_reg, o_send_next;
    logic [15:0]   o_rate_reg, o_rate_next;
    logic          o_upd_reg, o_upd_next;

    logic          in_take;
    logic          out_free;
    logic [AW-1:0] lim [NA];
    logic [DW:0]   dsum [NA];
    logic [DW-1:0] ldig [NA];
    logic [16:0]   roll_abs;
    logic [16:0]   pitch_abs;
    logic [2:0]    tick_flags;
    logic [AW:0]   trial;
    logic [QW-1:0] quo_shift;

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    // comparison limits for the three accumulators
    assign lim[lwas_pkg::ACC_HB]  = {8'd0, tmo_reg};
    assign lim[lwas_pkg::ACC_WIN] = lwas_pkg::RATE_WINDOW_US;
    assign lim[lwas_pkg::ACC_SND] = {12'd0, period_reg};

    // digit adders and limit digits
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            dsum[i] = {1'b0, acc_reg[i][DW-1:0]} + {1'b0, dt_reg[DW-1:0]}
                      + {{DW{1'b0}}, carry_reg[i]};
            ldig[i] = lim[i][{dig_reg, 2'b00} +: DW];
        end
    end

    // limit flags of a tick, from the request fields
    assign roll_abs  = roll_cdeg[15]  ? (17'd0 - {roll_cdeg[15], roll_cdeg})
                                      : {1'b0, roll_cdeg};
    assign pitch_abs = pitch_cdeg[15] ? (17'd0 - {pitch_cdeg[15], pitch_cdeg})
                                      : {1'b0, pitch_cdeg};
    assign tick_flags[lwas_pkg::FLAG_ATT]  = (roll_abs > {2'd0, att_lim_reg})
                                          || (pitch_abs > {2'd0, att_lim_reg});
    assign tick_flags[lwas_pkg::FLAG_TEMP] = $signed(imu_temp_cdeg) > $signed(temp_lim_reg);
    assign tick_flags[lwas_pkg::FLAG_BATT] = battery_percent < batt_low_reg;

    // divider trial subtract
    assign trial     = {rem_reg, quo_reg[QW-1]} - {1'b0, acc_reg[lwas_pkg::ACC_WIN]};
    assign quo_shift = {quo_reg[QW-2:0], !trial[AW]};

    // next state
    always_comb
    begin
        state_next    = state_reg;
        dig_next      = dig_reg;
        cnt_next      = cnt_reg;
        dt_next       = dt_reg;
        carry_next    = carry_reg;
        ge_next       = ge_reg;
        beat_next     = beat_reg;
        rate_next     = rate_reg;
        online_next   = online_reg;
        armed_next    = armed_reg;
        flags_next    = flags_reg;
        send_next     = send_reg;
        upd_next      = upd_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        for (int i = 0; i < NA; i++)
        begin
            acc_next[i] = acc_reg[i];
        end
        att_lim_next  = att_lim_reg;
        temp_lim_next = temp_lim_reg;
        batt_low_next = batt_low_reg;
        tmo_next      = tmo_reg;
        period_next   = period_reg;
        out_valid_next = out_valid_reg;
        o_armed_next  = o_armed_reg;
        o_online_next = o_online_reg;
        o_flags_next  = o_flags_reg;
        o_send_next   = o_send_reg;
        o_rate_next   = o_rate_reg;
        o_upd_next    = o_upd_reg;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                lwas_pkg::CFG_ATT_LIMIT:   att_lim_next  = cfg_data[14:0];
                lwas_pkg::CFG_TEMP_LIMIT:  temp_lim_next = cfg_data[14:0];
                lwas_pkg::CFG_BATT_LOW:    batt_low_next = cfg_data[6:0];
                lwas_pkg::CFG_LINK_TMO:    tmo_next      = cfg_data[23:0];
                lwas_pkg::CFG_SEND_PERIOD: period_next   = cfg_data[19:0];
                default: ;
            endcase
        end

        // result register drains
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    send_next  = 1'b0;
                    upd_next   = 1'b0;
                    state_next = ST_DONE;
                    unique case (func)
                        lwas_pkg::FUNC_TICK:
                        begin
                            flags_next = tick_flags;
                            dt_next    = {16'd0, elapsed_us};
                            carry_next = '0;
                            ge_next    = '1;
                            dig_next   = '0;
                            state_next = ST_ADD;
                        end
                        lwas_pkg::FUNC_BEAT:
                        begin
                            if (beat_reg != 16'hFFFF)
                            begin
                                beat_next = beat_reg + 16'd1;
                            end
                            acc_next[lwas_pkg::ACC_HB] = '0;
                            online_next = 1'b1;
                        end
                        lwas_pkg::FUNC_ARM:
                        begin
                            if (!flags_reg[lwas_pkg::FLAG_ATT] && !flags_reg[lwas_pkg::FLAG_BATT])
                            begin
                                armed_next = 1'b1;
                            end
                        end
                        lwas_pkg::FUNC_DISARM:
                        begin
                            armed_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end

            // one digit of each sum and compare per cycle, lsb first
            ST_ADD:
            begin
                dt_next = {{DW{1'b0}}, dt_reg[AW-1:DW]};
                for (int i = 0; i < NA; i++)
                begin
                    acc_next[i]   = {dsum[i][DW-1:0], acc_reg[i][AW-1:DW]};
                    carry_next[i] = dsum[i][DW];
                    ge_next[i]    = (dsum[i][DW-1:0] > ldig[i])
                                 || ((dsum[i][DW-1:0] == ldig[i]) && ge_reg[i]);
                    // saturate on carry out of the top digit
                    if (dig_reg == lwas_pkg::DIGIT_CNT_W'(lwas_pkg::DIGITS - 1)
                        && dsum[i][DW])
                    begin
                        acc_next[i] = '1;
                        ge_next[i]  = 1'b1;
                    end
                end
                dig_next = dig_reg + 1'b1;
                if (dig_reg == lwas_pkg::DIGIT_CNT_W'(lwas_pkg::DIGITS - 1))
                begin
                    state_next = ST_DECIDE;
                end
            end

            // act on the compares
            ST_DECIDE:
            begin
                state_next = ST_DONE;
                if (ge_reg[lwas_pkg::ACC_SND])
                begin
                    send_next = 1'b1;
                    acc_next[lwas_pkg::ACC_SND] = '0;
                end
                if (ge_reg[lwas_pkg::ACC_HB])
                begin
                    online_next = 1'b0;
                end
                if (ge_reg[lwas_pkg::ACC_WIN])
                begin
                    rem_next   = '0;
                    quo_next   = {beat_reg, 8'd0};
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            // restoring division, one quotient bit per cycle
            ST_DIV:
            begin
                quo_next = quo_shift;
                if (!trial[AW])
                begin
                    rem_next = trial[AW-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[AW-2:0], quo_reg[QW-1]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lwas_pkg::QUO_CNT_W'(QW - 1))
                begin
                    rate_next  = (|quo_shift[QW-1:16]) ? 16'hFFFF : quo_shift[15:0];
                    acc_next[lwas_pkg::ACC_WIN] = '0;
                    beat_next  = '0;
                    upd_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end

            // hand the result to the output register
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_armed_next   = armed_reg;
                    o_online_next  = online_reg;
                    o_flags_next   = flags_reg;
                    o_send_next    = send_reg;
                    o_rate_next    = rate_reg;
                    o_upd_next     = upd_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dig_reg       <= '0;
            cnt_reg       <= '0;
            dt_reg        <= '0;
            carry_reg     <= '0;
            ge_reg        <= '0;
            beat_reg      <= '0;
            rate_reg      <= '0;
            online_reg    <= 1'b0;
            armed_reg     <= 1'b0;
            flags_reg     <= '0;
            send_reg      <= 1'b0;
            upd_reg       <= 1'b0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            for (int i = 0; i < NA; i++)
            begin
                acc_reg[i] <= '0;
            end
            att_lim_reg   <= lwas_pkg::ATT_LIMIT_RST;
            temp_lim_reg  <= lwas_pkg::TEMP_LIMIT_RST;
            batt_low_reg  <= lwas_pkg::BATT_LOW_RST;
            tmo_reg       <= lwas_pkg::LINK_TMO_RST;
            period_reg    <= lwas_pkg::SEND_PERIOD_RST;
            out_valid_reg <= 1'b0;
            o_armed_reg   <= 1'b0;
            o_online_reg  <= 1'b0;
            o_flags_reg   <= '0;
            o_send_reg    <= 1'b0;
            o_rate_reg    <= '0;
            o_upd_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dig_reg       <= dig_next;
            cnt_reg       <= cnt_next;
            dt_reg        <= dt_next;
            carry_reg     <= carry_next;
            ge_reg        <= ge_next;
            beat_reg      <= beat_next;
            rate_reg      <= rate_next;
            online_reg    <= online_next;
            armed_reg     <= armed_next;
            flags_reg     <= flags_next;
            send_reg      <= send_next;
            upd_reg       <= upd_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            for (int i = 0; i < NA; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
            att_lim_reg   <= att_lim_next;
            temp_lim_reg  <= temp_lim_next;
            batt_low_reg  <= batt_low_next;
            tmo_reg       <= tmo_next;
            period_reg    <= period_next;
            out_valid_reg <= out_valid_next;
            o_armed_reg   <= o_armed_next;
            o_online_reg  <= o_online_next;
            o_flags_reg   <= o_flags_next;
            o_send_reg    <= o_send_next;
            o_rate_reg    <= o_rate_next;
            o_upd_reg     <= o_upd_next;
        end
    end

    // result ports
    assign out_valid            = out_valid_reg;
    assign armed_flag           = o_armed_reg;
    assign link_online          = o_online_reg;
    assign attitude_exceeded    = o_flags_reg[lwas_pkg::FLAG_ATT];
    assign temperature_exceeded = o_flags_reg[lwas_pkg::FLAG_TEMP];
    assign battery_low          = o_flags_reg[lwas_pkg::FLAG_BATT];
    assign send_heartbeat       = o_send_reg;
    assign heart_rate_q8        = o_rate_reg;
    assign rate_updated         = o_upd_reg;

endmodule
